// ===== src/spsw_pkg.sv =====
// ----------------------------------------------------------------------------
// spsw_pkg: shared types and constants for the servo pulse relay switch
// Register map, configuration bundle and result bundle.
// ----------------------------------------------------------------------------
package spsw_pkg;

    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;
    localparam int unsigned PW_W   = 8;

    // Register indexes, taken from paddr[4:2].
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_DEADBAND  = 3'd1;
    localparam logic [2:0] REG_DEB_LIMIT = 3'd2;
    localparam logic [2:0] REG_INACTIVE  = 3'd3;
    localparam logic [2:0] REG_ON_DELAY  = 3'd4;
    localparam logic [2:0] REG_POLARITY  = 3'd5;

    localparam logic [7:0]  RST_THRESHOLD = 8'd166;
    localparam logic [5:0]  RST_DEADBAND  = 6'd5;
    localparam logic [3:0]  RST_DEB_LIMIT = 4'd5;
    localparam logic [15:0] RST_INACTIVE  = 16'd25000;
    localparam logic [7:0]  RST_ON_DELAY  = 8'd39;
    localparam logic        RST_POLARITY  = 1'b1;

    typedef struct packed {
        logic [7:0]  pulse_threshold;
        logic [5:0]  deadband;
        logic [3:0]  debounce_limit;
        logic [15:0] inactive_limit;
        logic [7:0]  on_delay;
        logic        long_pulse_activates;
    } t_cfg;

    typedef struct packed {
        logic            relay_on;
        logic            active;
        logic            pulse_done;
        logic [PW_W-1:0] pulse_width;
    } t_result;

endpackage

// ===== src/spsw_if.sv =====
// ----------------------------------------------------------------------------
// spsw_if: item channels of the servo pulse relay switch
// Valid/ready channels for input samples and for result items.
// ----------------------------------------------------------------------------
interface spsw_in_if;
    logic valid;
    logic ready;
    logic pulse_level;
    logic slow_tick;

    modport source (output valid, output pulse_level, output slow_tick, input ready);
    modport sink   (input valid, input pulse_level, input slow_tick, output ready);
endinterface

interface spsw_out_if
    import spsw_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            relay_on;
    logic            active;
    logic            pulse_done;
    logic [PW_W-1:0] pulse_width;

    modport source (output valid, output relay_on, output active, output pulse_done,
                    output pulse_width, input ready);
    modport sink   (input valid, input relay_on, input active, input pulse_done,
                    input pulse_width, output ready);
endinterface

// ===== src/servo_pulse_relay_switch_core.sv =====
// Path: an accepted sample is held in the input register, then its result in the result register.
// Throughput: one sample per cycle while the output is not stalled, set by the single state
// update between the input register and the result register.
// Reset: synchronous, active low; clears the valid flags and switch state and loads register defaults.
// ----------------------------------------------------------------------------
// servo_pulse_relay_switch_core: servo pulse relay switch, top level
// Times servo pulses, debounces long/short decisions and drives a relay.
// ----------------------------------------------------------------------------
module servo_pulse_relay_switch_core
    import spsw_pkg::*;
#(
    parameter int unsigned WIDTH_BITS = 8,
    parameter int unsigned IDLE_BITS  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spsw_in_if.sink           i_in,
    spsw_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_result result;
    t_result r_out;
    logic    r_s1_valid, r_s1_level, r_s1_tick;
    logic    r_out_valid;
    logic    advance;
    logic    in_ready;

    spsw_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The sample in the input register moves on whenever the result register is free or is being read out.
    assign advance  = r_s1_valid & (~r_out_valid | o_out.ready);
    assign in_ready = ~r_s1_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_s1_level <= i_in.pulse_level;
            r_s1_tick  <= i_in.slow_tick;
        end
    end

    spsw_core #(
        .WIDTH_BITS (WIDTH_BITS),
        .IDLE_BITS  (IDLE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_level  (r_s1_level),
        .i_tick   (r_s1_tick),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_out_valid;
    assign o_out.relay_on    = r_out.relay_on;
    assign o_out.active      = r_out.active;
    assign o_out.pulse_done  = r_out.pulse_done;
    assign o_out.pulse_width = r_out.pulse_width;

`ifndef SYNTHESIS
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("result register empty after a sample moved into it");

    a_stalled_sample_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> r_s1_valid)
        else $error("stalled sample lost from the input register");

    a_width_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.pulse_done) |-> (o_out.pulse_width == '0))
        else $error("pulse width shown on an item that ends no pulse");
`endif

endmodule

// ===== src/spsw_cfg.sv =====
// ----------------------------------------------------------------------------
// spsw_cfg: configuration register file
// APB-style write and read access to the six switch settings.
// ----------------------------------------------------------------------------
module spsw_cfg
    import spsw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pulse_threshold      <= RST_THRESHOLD;
            r_cfg.deadband             <= RST_DEADBAND;
            r_cfg.debounce_limit       <= RST_DEB_LIMIT;
            r_cfg.inactive_limit       <= RST_INACTIVE;
            r_cfg.on_delay             <= RST_ON_DELAY;
            r_cfg.long_pulse_activates <= RST_POLARITY;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_THRESHOLD: r_cfg.pulse_threshold      <= pwdata[7:0];
                REG_DEADBAND:  r_cfg.deadband             <= pwdata[5:0];
                REG_DEB_LIMIT: r_cfg.debounce_limit       <= pwdata[3:0];
                REG_INACTIVE:  r_cfg.inactive_limit       <= pwdata[15:0];
                REG_ON_DELAY:  r_cfg.on_delay             <= pwdata[7:0];
                REG_POLARITY:  r_cfg.long_pulse_activates <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_THRESHOLD: prdata = APB_DW'(r_cfg.pulse_threshold);
            REG_DEADBAND:  prdata = APB_DW'(r_cfg.deadband);
            REG_DEB_LIMIT: prdata = APB_DW'(r_cfg.debounce_limit);
            REG_INACTIVE:  prdata = APB_DW'(r_cfg.inactive_limit);
            REG_ON_DELAY:  prdata = APB_DW'(r_cfg.on_delay);
            REG_POLARITY:  prdata = APB_DW'(r_cfg.long_pulse_activates);
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/spsw_core.sv =====
// ----------------------------------------------------------------------------
// spsw_core: pulse timing, debounce and relay state
// Updates all switch state for one sample and forms its result.
// ----------------------------------------------------------------------------
module spsw_core
    import spsw_pkg::*;
#(
    parameter int unsigned WIDTH_BITS = 8,
    parameter int unsigned IDLE_BITS  = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_level,
    input  logic    i_tick,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    localparam int unsigned CMP_W = (IDLE_BITS > 16) ? IDLE_BITS : 16;
    localparam int unsigned JDG_W = ((WIDTH_BITS > 9) ? WIDTH_BITS : 9) + 2;
    localparam int unsigned EXT_W = (WIDTH_BITS > PW_W) ? WIDTH_BITS : PW_W;
    localparam logic [WIDTH_BITS-1:0] HIGH_MAX = {WIDTH_BITS{1'b1}};

    logic                  r_in_high, n_in_high;
    logic [IDLE_BITS-1:0]  r_low_cnt, n_low_cnt;
    logic [WIDTH_BITS-1:0] r_high_cnt, n_high_cnt;
    logic [3:0]            r_deb_cnt, n_deb_cnt;
    logic                  r_active, n_active;
    logic [7:0]            r_delay, n_delay;
    logic                  r_tick_pend, n_tick_pend;
    logic                  r_relay, n_relay;

    logic                    tick_any;
    logic [WIDTH_BITS-1:0]   high_base;
    logic signed [JDG_W-1:0] sw, upper, lower;
    logic                    is_long, is_short;
    logic [EXT_W-1:0]        width_ext;
    logic                    done;

    assign tick_any  = r_tick_pend | i_tick;
    assign high_base = r_in_high ? r_high_cnt : '0;
    assign sw        = JDG_W'($signed({1'b0, r_high_cnt}));
    assign upper     = JDG_W'($signed({1'b0, i_cfg.pulse_threshold}))
                     + JDG_W'($signed({1'b0, i_cfg.deadband}));
    assign lower     = JDG_W'($signed({1'b0, i_cfg.pulse_threshold}))
                     - JDG_W'($signed({1'b0, i_cfg.deadband}));
    assign is_long   = sw > upper;
    assign is_short  = sw < lower;
    assign width_ext = EXT_W'(r_high_cnt);

    always_comb begin
        n_in_high   = r_in_high;
        n_low_cnt   = r_low_cnt;
        n_high_cnt  = r_high_cnt;
        n_deb_cnt   = r_deb_cnt;
        n_active    = r_active;
        n_delay     = r_delay;
        n_tick_pend = tick_any;
        n_relay     = r_relay;
        done        = 1'b0;

        priority if (i_level) begin
            n_in_high  = 1'b1;
            n_high_cnt = (high_base < HIGH_MAX) ? high_base + 1'b1 : high_base;
        end else if (r_in_high) begin
            // Falling edge: judge the pulse, then run the on-delay on a latched or current tick.
            done = 1'b1;
            if (is_long) begin
                if (r_deb_cnt < i_cfg.debounce_limit) n_deb_cnt = r_deb_cnt + 1'b1;
                if (n_deb_cnt == i_cfg.debounce_limit) n_active = i_cfg.long_pulse_activates;
            end else if (is_short) begin
                if (r_deb_cnt != '0) n_deb_cnt = r_deb_cnt - 1'b1;
                if (n_deb_cnt == '0) n_active = ~i_cfg.long_pulse_activates;
            end
            if (tick_any) begin
                n_tick_pend = 1'b0;
                if (n_active) begin
                    if (r_delay >= i_cfg.on_delay) n_relay = 1'b1;
                    else n_delay = r_delay + 1'b1;
                end else begin
                    n_delay = '0;
                    n_relay = 1'b0;
                end
            end
            n_in_high  = 1'b0;
            n_high_cnt = '0;
            n_low_cnt  = '0;
        end else begin
            if (CMP_W'(r_low_cnt) < CMP_W'(i_cfg.inactive_limit)) begin
                n_low_cnt = r_low_cnt + 1'b1;
            end else begin
                // Signal lost: drop the relay, the active state and the on-delay count.
                n_relay  = 1'b0;
                n_active = 1'b0;
                n_delay  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_high   <= 1'b0;
            r_low_cnt   <= '0;
            r_high_cnt  <= '0;
            r_deb_cnt   <= '0;
            r_active    <= 1'b0;
            r_delay     <= '0;
            r_tick_pend <= 1'b0;
            r_relay     <= 1'b0;
        end else if (i_en) begin
            r_in_high   <= n_in_high;
            r_low_cnt   <= n_low_cnt;
            r_high_cnt  <= n_high_cnt;
            r_deb_cnt   <= n_deb_cnt;
            r_active    <= n_active;
            r_delay     <= n_delay;
            r_tick_pend <= n_tick_pend;
            r_relay     <= n_relay;
        end
    end

    always_comb begin
        o_result.relay_on    = n_relay;
        o_result.active      = n_active;
        o_result.pulse_done  = done;
        o_result.pulse_width = done ? width_ext[PW_W-1:0] : '0;
    end

endmodule
